>>> design/sbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants of the seen bitmap block
// Holds the request kind codes, the fixed field widths and the bitmap row
// geometry used by every module of the block.
// ----------------------------------------------------------------------------
package sbc_pkg;

	// Fixed field widths of the request and the result.
	localparam int KIND_W  = 2;
	localparam int ID_W    = 11;
	localparam int COUNT_W = 11;

	// Largest count the result field can show.
	localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

	// The bitmap memory holds rows of this many entry bits.
	localparam int ROW_BITS = 32;
	localparam int BIT_W    = $clog2(ROW_BITS);

	// Request kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_MARK  = 2'd0,
		KIND_TEST  = 2'd1,
		KIND_COUNT = 2'd2,
		KIND_ERASE = 2'd3
	} kind_t;

	// Update of the bitmap store from the execute stage.
	typedef struct packed {
		logic wr;   // write the modified row back
		logic clr;  // erase every row of both lists
	} bm_upd_t;

endpackage

>>> design/sbc_bitmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_bitmap: row memory holding both seen lists
// Rows of entry bits with a registered read, one valid bit per row so that
// an erase clears everything at once, and bypass of a same-row write.
// ----------------------------------------------------------------------------
module sbc_bitmap
	import sbc_pkg::*;
#(
	parameter int ADDR_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	input  bm_upd_t             upd,
	input  logic [ROW_BITS-1:0] wr_data,
	output logic [ROW_BITS-1:0] row
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [ROW_BITS-1:0] mem [DEPTH];
	logic [ROW_BITS-1:0] rd_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [DEPTH-1:0]    valid_q;
	logic                fwd;

	// A request entering while the previous one writes the same row takes
	// the new row instead of the stale memory word.
	assign fwd = upd.wr && (rd_addr == addr_q);

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (upd.wr) begin
			mem[addr_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q   <= fwd ? wr_data : mem[rd_addr];
			addr_q <= rd_addr;
		end
	end

	// Row valid bits; a row never written since reset or erase reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd.clr) begin
			valid_q <= '0;
		end else if (upd.wr) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	assign row = valid_q[addr_q] ? rd_q : '0;

	// A write and an erase never come from the same request.
	a_wr_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(upd.wr && upd.clr))
		else $error("bitmap write and erase in the same cycle");

endmodule

>>> design/sbc_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_count: running totals of set bits
// Keeps one counter per list, gives the selected list's count after the
// current request, saturated to the result field.
// ----------------------------------------------------------------------------
module sbc_count
	import sbc_pkg::*;
#(
	parameter int ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               erase,
	input  logic               inc,
	input  logic               list,
	output logic [COUNT_W-1:0] count
);

	localparam int CNT_W = $clog2(ENTRIES + 1);

	logic [CNT_W-1:0] maker_q;
	logic [CNT_W-1:0] exhibit_q;
	logic [CNT_W-1:0] cur;
	logic [CNT_W-1:0] nxt;

	// Total of the selected list after this request.
	always_comb begin
		cur = list ? exhibit_q : maker_q;
		if (erase) begin
			nxt = '0;
		end else if (inc) begin
			nxt = cur + CNT_W'(1);
		end else begin
			nxt = cur;
		end
	end

	// Saturate to the width of the result field.
	assign count = ({1'b0, nxt} > (CNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX
		: COUNT_W'(nxt);

	// Counter update when the request leaves the execute stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maker_q   <= '0;
			exhibit_q <= '0;
		end else if (step) begin
			if (erase) begin
				maker_q   <= '0;
				exhibit_q <= '0;
			end else if (list) begin
				exhibit_q <= nxt;
			end else begin
				maker_q <= nxt;
			end
		end
	end

	// A list can never hold more set bits than it has entries.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, maker_q} <= (CNT_W + 1)'(ENTRIES))
		&& ({1'b0, exhibit_q} <= (CNT_W + 1)'(ENTRIES)))
		else $error("running total exceeds table size");

endmodule

>>> design/seen_bitmap_with_count_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seen_bitmap_with_count_top: two seen lists with running counts
// Marks and tests entries of the maker and exhibit lists, reads the count
// of set bits of a list, and erases both lists.
//
//   channel   direction   handshake              payload
//   request   in          req_valid, req_stall   kind, which_list, entry_id
//   result    out         res_valid, res_stall   was_set, newly_set,
//                                                seen_count, out_of_range
//
// One request is taken every cycle while req_stall is low; the registered
// row read of the bitmap memory is loaded together with the execute stage
// request register, and the result then moves into the output register.
// Reset clears the row valid bits and the totals at once, so requests are
// taken as soon as reset is released.
// A stalled result holds in the output register while one more request
// waits in the execute stage; only then is req_stall raised.
// ----------------------------------------------------------------------------
module seen_bitmap_with_count_top
	import sbc_pkg::*;
#(
	parameter int ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic               which_list,
	input  logic [ID_W-1:0]    entry_id,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               was_set,
	output logic               newly_set,
	output logic [COUNT_W-1:0] seen_count,
	output logic               out_of_range
);

	localparam int ROWS   = (ENTRIES + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = ROW_AW + 1;

	logic                accept;
	logic                advance;
	logic                v_s1;
	kind_t               kind_s1;
	logic                list_s1;
	logic [ID_W-1:0]     id_s1;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ROW_BITS-1:0] row;
	logic [ROW_BITS-1:0] wr_data;
	bm_upd_t             upd;
	logic                entry_op;
	logic                oor;
	logic                hit;
	logic                was;
	logic                fresh;
	logic                erase;
	logic [COUNT_W-1:0]  count;
	logic                res_valid_q;
	logic                was_q;
	logic                fresh_q;
	logic [COUNT_W-1:0]  count_q;
	logic                oor_q;

	// Handshake: the execute stage moves on when the output register is free.
	assign advance   = v_s1 && (!res_valid_q || !res_stall);
	assign req_stall = v_s1 && res_valid_q && res_stall;
	assign accept    = req_valid && !req_stall;

	// Row address: list in the top bit, row of the entry below it.
	assign rd_addr = {which_list, entry_id[BIT_W +: ROW_AW]};

	// Execute stage request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_t'(kind);
			list_s1 <= which_list;
			id_s1   <= entry_id;
		end
	end

	sbc_bitmap #(
		.ADDR_W(ADDR_W)
	) u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.upd    (upd),
		.wr_data(wr_data),
		.row    (row)
	);

	// Decode of the request in the execute stage.
	always_comb begin
		entry_op = (kind_s1 == KIND_MARK) || (kind_s1 == KIND_TEST);
		erase    = (kind_s1 == KIND_ERASE);
		oor      = entry_op && ({1'b0, id_s1} >= (ID_W + 1)'(ENTRIES));
		hit      = row[id_s1[BIT_W-1:0]];
		was      = entry_op && !oor && hit;
		fresh    = (kind_s1 == KIND_MARK) && !oor && !hit;
		wr_data  = row | (ROW_BITS'(1) << id_s1[BIT_W-1:0]);
		upd.wr   = advance && fresh;
		upd.clr  = advance && erase;
	end

	sbc_count #(
		.ENTRIES(ENTRIES)
	) u_count (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.erase (erase),
		.inc   (fresh),
		.list  (list_s1),
		.count (count)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			was_q   <= was;
			fresh_q <= fresh;
			count_q <= count;
			oor_q   <= oor;
		end
	end

	assign res_valid    = res_valid_q;
	assign was_set      = was_q;
	assign newly_set    = fresh_q;
	assign seen_count   = count_q;
	assign out_of_range = oor_q;

	// A mark that sets its bit cannot have found it set already.
	a_fresh_not_was: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(was_set && newly_set))
		else $error("result reports a bit both set and newly set");

	// An ignored entry never changes state.
	a_oor_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_of_range && (was_set || newly_set)))
		else $error("out of range request touched the bitmap");

	// A request leaving the execute stage always shows up as a result.
	a_advance_res: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid)
		else $error("result lost after execute stage");

	// The request side is stalled only when both stages are occupied.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v_s1 && res_valid_q))
		else $error("request stalled with a free stage");

endmodule
